// ===== rtl/rvcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rvcc_pkg: shared types and constants of the compressed instruction encoder
// Request and response payloads, the check flags that pass between stages,
// the class codes, the base opcodes of the 16-bit forms and the CSR map.
// ----------------------------------------------------------------------------
package rvcc_pkg;

   // CSR port
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic CsrIdxXlenMode = 1'b0;   // paddr[2] selects the register slot

   localparam logic XlenRv32 = 1'b0;

   // Compression classes
   localparam logic [4:0] ClsAdd   = 5'd1;
   localparam logic [4:0] ClsMv    = 5'd2;
   localparam logic [4:0] ClsJalr  = 5'd3;
   localparam logic [4:0] ClsJr    = 5'd4;
   localparam logic [4:0] ClsAlu   = 5'd5;
   localparam logic [4:0] ClsLi    = 5'd6;
   localparam logic [4:0] ClsLui   = 5'd7;
   localparam logic [4:0] ClsSlli  = 5'd8;
   localparam logic [4:0] ClsSrxi  = 5'd9;
   localparam logic [4:0] ClsAddi  = 5'd10;
   localparam logic [4:0] ClsJal   = 5'd11;
   localparam logic [4:0] ClsJ     = 5'd12;
   localparam logic [4:0] ClsAndi  = 5'd13;
   localparam logic [4:0] ClsBeqz  = 5'd14;
   localparam logic [4:0] ClsBnez  = 5'd15;
   localparam logic [4:0] ClsLw    = 5'd16;
   localparam logic [4:0] ClsFlw   = 5'd17;
   localparam logic [4:0] ClsFld   = 5'd18;
   localparam logic [4:0] ClsSw    = 5'd19;
   localparam logic [4:0] ClsFsw   = 5'd20;
   localparam logic [4:0] ClsFsd   = 5'd21;
   localparam logic [4:0] ClsAluW  = 5'd22;
   localparam logic [4:0] ClsAddiw = 5'd23;
   localparam logic [4:0] ClsLd    = 5'd24;
   localparam logic [4:0] ClsSd    = 5'd25;

   // Sub-operation that selects srai and addw
   localparam logic [1:0] SubAlt = 2'd1;

   // Base opcodes of the compressed forms
   localparam logic [15:0] OpcAdd    = 16'h9002;
   localparam logic [15:0] OpcMv     = 16'h8002;
   localparam logic [15:0] OpcAlu    = 16'h8C01;
   localparam logic [15:0] OpcLi     = 16'h4001;
   localparam logic [15:0] OpcLui    = 16'h6001;
   localparam logic [15:0] OpcSlli   = 16'h0002;
   localparam logic [15:0] OpcSrli   = 16'h8001;
   localparam logic [15:0] OpcSraBit = 16'h0400;
   localparam logic [15:0] OpcAddi   = 16'h0001;
   localparam logic [15:0] OpcAndi   = 16'h8801;
   localparam logic [15:0] OpcAluW   = 16'h9C01;
   localparam logic [15:0] OpcAddwBit = 16'h0020;
   localparam logic [15:0] OpcJ      = 16'hA001;
   localparam logic [15:0] OpcJal    = 16'h2001;
   localparam logic [15:0] OpcAddiw  = 16'h2001;
   localparam logic [15:0] OpcBeqz   = 16'hC001;
   localparam logic [15:0] OpcBnez   = 16'hE001;
   localparam logic [15:0] OpcLw     = 16'h4000;
   localparam logic [15:0] OpcFlw    = 16'h6000;
   localparam logic [15:0] OpcFld    = 16'h2000;
   localparam logic [15:0] OpcSw     = 16'hC000;
   localparam logic [15:0] OpcFsw    = 16'hE000;
   localparam logic [15:0] OpcFsd    = 16'hA000;
   localparam logic [15:0] OpcLd     = 16'h6000;
   localparam logic [15:0] OpcSd     = 16'hE000;
   localparam logic [15:0] OpcSpBit  = 16'h0002;
   localparam logic [15:0] OpcNop    = 16'h0001;

   typedef struct packed {
      logic [4:0]  op_class;
      logic [1:0]  sub_op;
      logic [4:0]  dest_reg;
      logic [4:0]  src_reg;
      logic        src_is_register;
      logic [5:0]  other_reg;
      logic [4:0]  base_reg;
      logic [31:0] imm;
      logic [31:0] disp;
      logic        first_pass;
      logic        is_move_word;
   } req_type;

   typedef struct packed {
      logic [15:0] encoding;
      logic        compressible;
   } rsp_type;

   // Checks worked out in the first stage and used by the encoding stage
   typedef struct packed {
      logic       rd_nz;
      logic       rs_nz;
      logic       r_nz;
      logic       r_eq_rd;
      logic       rs_eq_rd;
      logic       r_is1;
      logic       r_is2;
      logic       creg_rd;
      logic       creg_rs;
      logic       creg_r;
      logic       creg_base;
      logic       base_is2;
      logic       v_zero;
      logic       v_s6;
      logic       v_lui_ok;
      logic       v_sh_ok;
      logic       v_sp16_ok;
      logic       v_spn_ok;
      logic       mem_a4;
      logic       mem_a8;
      logic       lt80;
      logic       lt100;
      logic       lt200;
      logic       j_ok;
      logic       b_ok;
      logic       br_reg_ok;
      logic [2:0] br_reg;
   } flags_type;

endpackage

// ===== rtl/rvcc_check.sv =====
// ----------------------------------------------------------------------------
// rvcc_check: operand checks of the compressed instruction encoder
// Register comparisons, register-class tests and the range and alignment
// tests of the immediate and displacement, for every form at once.
// ----------------------------------------------------------------------------
module rvcc_check (
   input  rvcc_pkg::req_type   req,
   output rvcc_pkg::flags_type flags
);

   logic [31:0] v;
   logic [31:0] d;
   logic [5:0]  r;
   logic        r_absent;
   logic [5:0]  br_reg6;

   assign v = req.imm;
   assign d = req.disp;
   assign r = req.other_reg;

   // A branch takes its register from other_reg unless that is absent or x0.
   assign r_absent = (r == 6'd0) || (r == 6'd32);
   assign br_reg6  = r_absent ? {1'b0, req.src_reg} : r;

   always_comb begin
      flags.rd_nz     = req.dest_reg != 5'd0;
      flags.rs_nz     = req.src_reg != 5'd0;
      flags.r_nz      = r != 6'd0;
      flags.r_eq_rd   = r == {1'b0, req.dest_reg};
      flags.rs_eq_rd  = req.src_reg == req.dest_reg;
      flags.r_is1     = r == 6'd1;
      flags.r_is2     = r == 6'd2;
      flags.creg_rd   = req.dest_reg[4:3] == 2'b01;
      flags.creg_rs   = req.src_reg[4:3] == 2'b01;
      flags.creg_r    = r[5:3] == 3'b001;
      flags.creg_base = req.base_reg[4:3] == 2'b01;
      flags.base_is2  = req.base_reg == 5'd2;
      flags.v_zero    = v == 32'd0;
      flags.v_s6      = (&v[31:5]) || !(|v[31:5]);
      flags.v_lui_ok  = (v[11:0] == 12'd0) && (v != 32'd0) &&
                        ((&v[31:17]) || !(|v[31:17]));
      flags.v_sh_ok   = (v[31:6] == 26'd0) && (v != 32'd0);
      flags.v_sp16_ok = (v != 32'd0) && (v[3:0] == 4'd0) &&
                        ((&v[31:9]) || !(|v[31:9]));
      flags.v_spn_ok  = (v != 32'd0) && (v[1:0] == 2'd0) && (v[31:10] == 22'd0);
      flags.mem_a4    = !v[31] && (v[1:0] == 2'd0);
      flags.mem_a8    = !v[31] && (v[2:0] == 3'd0);
      flags.lt80      = v[31:7] == 25'd0;
      flags.lt100     = v[31:8] == 24'd0;
      flags.lt200     = v[31:9] == 23'd0;
      flags.j_ok      = req.first_pass ||
                        (!d[0] && ((&d[31:11]) || !(|d[31:11])));
      flags.b_ok      = req.first_pass ||
                        (!d[0] && ((&d[31:8]) || !(|d[31:8])));
      flags.br_reg_ok = (r_absent || (req.src_reg == 5'd0)) &&
                        (br_reg6[5:3] == 3'b001);
      flags.br_reg    = br_reg6[2:0];
   end

endmodule

// ===== rtl/rvcc_format.sv =====
// ----------------------------------------------------------------------------
// rvcc_format: encoding stage of the compressed instruction encoder
// Picks the form of the class from the registered checks and packs the
// registers and scrambled immediate bits into the 16-bit word.
// ----------------------------------------------------------------------------
module rvcc_format (
   input  rvcc_pkg::req_type   req,
   input  rvcc_pkg::flags_type flags,
   input  logic                xlen_mode,
   output rvcc_pkg::rsp_type   rsp
);

   function automatic logic [15:0] f_cr(logic [15:0] op, logic [4:0] rs, logic [4:0] rd);
      f_cr = op | {9'd0, rs, 2'd0} | {4'd0, rd, 7'd0};
   endfunction

   function automatic logic [15:0] f_ci(logic [15:0] op, logic [4:0] rd, logic [5:0] i);
      f_ci = op | {4'd0, rd, 7'd0} | {3'd0, i[5], 12'd0} | {9'd0, i[4:0], 2'd0};
   endfunction

   function automatic logic [15:0] f_cl(logic [15:0] op, logic [2:0] hi, logic [2:0] lo,
                                        logic [5:0] i);
      f_cl = op | {6'd0, hi, 7'd0} | {11'd0, lo, 2'd0} | {9'd0, i[2:0], 4'd0} |
             {3'd0, i[5:3], 10'd0};
   endfunction

   logic [31:0] v;
   logic [31:0] d;
   logic        rv32;
   logic [10:0] j_i;
   logic [7:0]  b_i;
   logic [5:0]  sp16_i;
   logic [7:0]  spn_i;
   logic [5:0]  cl_i;
   logic [5:0]  sp_u;
   logic        len8;
   logic        store;
   logic        nz_rd;
   logic [15:0] mop;
   logic [4:0]  mreg;
   logic        creg_m;
   logic        m_align;
   logic        cl_lt;
   logic        sp_lt;
   logic [15:0] mem_enc;
   logic [15:0] jop;
   logic [15:0] bop;
   logic [15:0] j_enc;
   logic [15:0] b_enc;
   logic [15:0] enc;

   assign v    = req.imm;
   assign d    = req.disp;
   assign rv32 = xlen_mode == rvcc_pkg::XlenRv32;

   // Immediate bit scrambles of the jump, branch and stack-pointer forms.
   assign j_i    = {d[11], d[4], d[9], d[8], d[10], d[6], d[7], d[3], d[2], d[1], d[5]};
   assign b_i    = {d[8], d[4], d[3], d[7], d[6], d[2], d[1], d[5]};
   assign sp16_i = {v[9], v[4], v[6], v[8], v[7], v[5]};
   assign spn_i  = {v[5], v[4], v[9], v[8], v[7], v[6], v[2], v[3]};

   // Offset folding of the register-based and sp-based memory forms.
   assign cl_i = {v[5:3], v[2] | v[7], v[1] | v[6], v[0]};
   assign sp_u = v[5:0] | {3'd0, v[8:6]};

   always_comb begin
      len8  = 1'b0;
      store = 1'b0;
      nz_rd = 1'b0;
      mop   = rvcc_pkg::OpcLw;
      unique case (req.op_class)
         rvcc_pkg::ClsLw:  begin
            nz_rd = 1'b1;
         end
         rvcc_pkg::ClsFlw: begin
            mop = rvcc_pkg::OpcFlw;
         end
         rvcc_pkg::ClsFld: begin
            mop  = rvcc_pkg::OpcFld;
            len8 = 1'b1;
         end
         rvcc_pkg::ClsSw:  begin
            mop   = rvcc_pkg::OpcSw;
            store = 1'b1;
         end
         rvcc_pkg::ClsFsw: begin
            mop   = rvcc_pkg::OpcFsw;
            store = 1'b1;
         end
         rvcc_pkg::ClsFsd: begin
            mop   = rvcc_pkg::OpcFsd;
            store = 1'b1;
            len8  = 1'b1;
         end
         rvcc_pkg::ClsLd:  begin
            mop   = rvcc_pkg::OpcLd;
            len8  = 1'b1;
            nz_rd = 1'b1;
         end
         rvcc_pkg::ClsSd:  begin
            mop   = rvcc_pkg::OpcSd;
            store = 1'b1;
            len8  = 1'b1;
         end
         default: begin
            mop = rvcc_pkg::OpcLw;
         end
      endcase
   end

   assign mreg    = store ? req.src_reg : req.dest_reg;
   assign creg_m  = store ? flags.creg_rs : flags.creg_rd;
   assign m_align = len8 ? flags.mem_a8 : flags.mem_a4;
   assign cl_lt   = len8 ? flags.lt100 : flags.lt80;
   assign sp_lt   = len8 ? flags.lt200 : flags.lt100;

   always_comb begin
      mem_enc = 16'd0;
      if (!m_align) begin
         mem_enc = 16'd0;
      end else if (flags.creg_base && creg_m) begin
         if (cl_lt) begin
            mem_enc = f_cl(mop, req.base_reg[2:0], mreg[2:0], cl_i);
         end
      end else if (flags.base_is2 && sp_lt) begin
         if (store) begin
            mem_enc = (mop | rvcc_pkg::OpcSpBit) | {9'd0, mreg, 2'd0} |
                      {3'd0, sp_u, 7'd0};
         end else if (!(nz_rd && !flags.rd_nz)) begin
            mem_enc = f_ci(mop | rvcc_pkg::OpcSpBit, mreg, sp_u);
         end
      end
   end

   assign jop   = (req.op_class == rvcc_pkg::ClsJal) ? rvcc_pkg::OpcJal : rvcc_pkg::OpcJ;
   assign bop   = (req.op_class == rvcc_pkg::ClsBnez) ? rvcc_pkg::OpcBnez : rvcc_pkg::OpcBeqz;
   assign j_enc = flags.j_ok ? (jop | {3'd0, j_i, 2'd0}) : 16'd0;
   assign b_enc = (flags.br_reg_ok && flags.b_ok) ?
                  (bop | {6'd0, flags.br_reg, 7'd0} | {9'd0, b_i[4:0], 2'd0} |
                   {3'd0, b_i[7:5], 10'd0}) : 16'd0;

   always_comb begin
      enc = 16'd0;
      unique case (req.op_class)
         rvcc_pkg::ClsAdd: begin
            if (flags.rs_nz && flags.rd_nz && flags.r_eq_rd) begin
               enc = f_cr(rvcc_pkg::OpcAdd, req.src_reg, req.dest_reg);
            end
         end
         rvcc_pkg::ClsMv: begin
            if (flags.rd_nz) begin
               if (req.src_is_register && flags.rs_nz) begin
                  enc = f_cr(rvcc_pkg::OpcMv, req.src_reg, req.dest_reg);
               end else begin
                  enc = f_ci(rvcc_pkg::OpcLi, req.dest_reg, 6'd0);
               end
            end
         end
         rvcc_pkg::ClsJalr: begin
            if (flags.r_is1 && flags.rd_nz && flags.v_zero) begin
               enc = f_cr(rvcc_pkg::OpcAdd, 5'd0, req.dest_reg);
            end
         end
         rvcc_pkg::ClsJr: begin
            if (flags.rd_nz && flags.v_zero) begin
               enc = f_cr(rvcc_pkg::OpcMv, 5'd0, req.dest_reg);
            end
         end
         rvcc_pkg::ClsAlu: begin
            if (flags.r_eq_rd && flags.creg_rs && flags.creg_rd) begin
               enc = f_cr(rvcc_pkg::OpcAlu | {9'd0, req.sub_op, 5'd0},
                          {2'd0, req.src_reg[2:0]}, {2'd0, req.dest_reg[2:0]});
            end
         end
         rvcc_pkg::ClsLi: begin
            if (flags.rd_nz && flags.v_s6) begin
               enc = f_ci(rvcc_pkg::OpcLi, req.dest_reg, v[5:0]);
            end
         end
         rvcc_pkg::ClsLui: begin
            // x2 as target belongs to the stack adjust form, zero is reserved.
            if (flags.v_lui_ok && flags.rd_nz && (req.dest_reg != 5'd2)) begin
               enc = f_ci(rvcc_pkg::OpcLui, req.dest_reg, v[17:12]);
            end
         end
         rvcc_pkg::ClsSlli: begin
            if (!(v[5] && rv32) && flags.r_eq_rd && flags.r_nz && flags.v_sh_ok) begin
               enc = f_ci(rvcc_pkg::OpcSlli, req.dest_reg, v[5:0]);
            end
         end
         rvcc_pkg::ClsSrxi: begin
            if (!(v[5] && rv32) && flags.r_eq_rd && flags.creg_r && flags.v_sh_ok) begin
               enc = f_ci(rvcc_pkg::OpcSrli |
                          ((req.sub_op == rvcc_pkg::SubAlt) ? rvcc_pkg::OpcSraBit : 16'd0),
                          {2'd0, req.other_reg[2:0]}, v[5:0]);
            end
         end
         rvcc_pkg::ClsAddi: begin
            if (flags.r_eq_rd && flags.r_nz && !flags.v_zero && flags.v_s6) begin
               enc = f_ci(rvcc_pkg::OpcAddi, req.dest_reg, v[5:0]);
            end else if (flags.r_eq_rd && flags.r_is2 && flags.v_sp16_ok) begin
               enc = f_ci(rvcc_pkg::OpcLui, 5'd2, sp16_i);
            end else if (flags.r_is2 && flags.creg_rd && flags.v_spn_ok) begin
               enc = {3'd0, spn_i, req.dest_reg[2:0], 2'd0};
            end else if (flags.r_eq_rd && !flags.r_nz && flags.v_zero) begin
               enc = rvcc_pkg::OpcNop;
            end
         end
         rvcc_pkg::ClsJal: begin
            if (rv32 && flags.r_is1) begin
               enc = j_enc;
            end
         end
         rvcc_pkg::ClsJ: begin
            enc = j_enc;
         end
         rvcc_pkg::ClsAndi: begin
            if (flags.r_eq_rd && flags.creg_r && flags.v_s6) begin
               enc = f_ci(rvcc_pkg::OpcAndi, {2'd0, req.other_reg[2:0]}, v[5:0]);
            end
         end
         rvcc_pkg::ClsBeqz, rvcc_pkg::ClsBnez: begin
            enc = b_enc;
         end
         rvcc_pkg::ClsLw, rvcc_pkg::ClsFld, rvcc_pkg::ClsSw, rvcc_pkg::ClsFsd: begin
            enc = mem_enc;
         end
         rvcc_pkg::ClsFlw, rvcc_pkg::ClsFsw: begin
            if (rv32) begin
               enc = mem_enc;
            end
         end
         rvcc_pkg::ClsLd, rvcc_pkg::ClsSd: begin
            if (!rv32) begin
               enc = mem_enc;
            end
         end
         rvcc_pkg::ClsAluW: begin
            if (!rv32 && flags.r_eq_rd && flags.creg_rs && flags.creg_rd) begin
               enc = f_cr(rvcc_pkg::OpcAluW |
                          ((req.sub_op == rvcc_pkg::SubAlt) ? rvcc_pkg::OpcAddwBit : 16'd0),
                          {2'd0, req.src_reg[2:0]}, {2'd0, req.dest_reg[2:0]});
            end
         end
         rvcc_pkg::ClsAddiw: begin
            // A word move is sext.w, which is addiw with a zero immediate.
            if (!rv32) begin
               if (req.is_move_word) begin
                  if (flags.rs_eq_rd && flags.rs_nz) begin
                     enc = f_ci(rvcc_pkg::OpcAddiw, req.dest_reg, 6'd0);
                  end
               end else if (flags.r_eq_rd && flags.r_nz && flags.v_s6) begin
                  enc = f_ci(rvcc_pkg::OpcAddiw, req.dest_reg, v[5:0]);
               end
            end
         end
         default: begin
            enc = 16'd0;
         end
      endcase
   end

   assign rsp.encoding     = enc;
   assign rsp.compressible = enc != 16'd0;

endmodule

// ===== rtl/rvc_instruction_compressor.sv =====
// ----------------------------------------------------------------------------
// rvc_instruction_compressor: RISC-V compressed instruction encoder
// Turns one decoded instruction into its 16-bit compressed form, or 0 with
// compressible cleared, through a three-stage pipeline.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                       payload
//   req_*     in          req_valid / req_ready           rvcc_pkg::req_type
//   rsp_*     out         rsp_valid / rsp_ready           rvcc_pkg::rsp_type
//   APB       in/out      psel, penable, pwrite, pready   xlen_mode at 0x0
//
// A request passes an input register, a check register and the output
// register, in that order. One request is taken per cycle unless a stalled
// response holds the output. All stages advance together and hold while a
// response waits on rsp_ready. Synchronous reset clears the stage valid bits
// and sets xlen_mode to RV32.
//
module rvc_instruction_compressor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rvcc_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rvcc_pkg::rsp_type                   rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rvcc_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [rvcc_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [rvcc_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                pready
);

   logic                xlen_ff;
   logic                xlen_in;
   logic                advance;
   logic                s1_valid_ff;
   rvcc_pkg::req_type   s1_req_ff;
   logic                s2_valid_ff;
   rvcc_pkg::req_type   s2_req_ff;
   rvcc_pkg::flags_type s2_flags_ff;
   logic                rsp_valid_ff;
   rvcc_pkg::rsp_type   rsp_ff;
   rvcc_pkg::flags_type check_flags;
   rvcc_pkg::rsp_type   format_rsp;

   // Configuration register
   assign pready = 1'b1;

   always_comb begin
      xlen_in = xlen_ff;
      if (psel && penable && pwrite && (paddr[2] == rvcc_pkg::CsrIdxXlenMode)) begin
         xlen_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xlen_ff <= rvcc_pkg::XlenRv32;
      end else begin
         xlen_ff <= xlen_in;
      end
   end

   assign prdata = (paddr[2] == rvcc_pkg::CsrIdxXlenMode) ?
                   {{(rvcc_pkg::CsrDataWidth-1){1'b0}}, xlen_ff} : '0;

   // The whole pipeline moves unless the output holds an untaken response.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   rvcc_check u_check (
      .req   (s1_req_ff),
      .flags (check_flags)
   );

   rvcc_format u_format (
      .req       (s2_req_ff),
      .flags     (s2_flags_ff),
      .xlen_mode (xlen_ff),
      .rsp       (format_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff   <= req_payload;
         s2_req_ff   <= s1_req_ff;
         s2_flags_ff <= check_flags;
         rsp_ff      <= format_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_flag_matches_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.compressible == (rsp_payload.encoding != 16'd0)))
      else $error("compressible flag disagrees with the encoded word");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while a response is stalled");

   a_accept_enters_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted request missing from the first stage");

   a_stall_keeps_s2: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !advance) |=> (s2_valid_ff && $stable(s2_req_ff)))
      else $error("second stage lost its request during a stall");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: compressed instruction encoder
// Drives decoded instructions through the request channel and checks every
// response against an independent encoder. It covers directed corner cases
// and random instructions shaped to meet each form's checks, in both base
// modes, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WatchdogLimit = 2000;
   localparam int TailCycles = 8;

   localparam logic XlenRv64 = 1'b1;
   localparam logic [rvcc_pkg::CsrAddrWidth-1:0] XlenModeAddr =
      {rvcc_pkg::CsrIdxXlenMode, 2'b00};

   // Register numbers with a fixed role, and the marker of an absent register
   localparam int RegZero   = 0;
   localparam int RegLink   = 1;
   localparam int RegSp     = 2;
   localparam int RegAbsent = 32;

   // Sub-operations of the register ALU class
   localparam logic [1:0] SubSub = 2'd0;
   localparam logic [1:0] SubXor = 2'd1;
   localparam logic [1:0] SubOr  = 2'd2;
   localparam logic [1:0] SubAnd = 2'd3;

   // addi16sp shares its base opcode with lui
   localparam logic [15:0] OpcAddi16sp = rvcc_pkg::OpcLui;

   // Immediate bit orders of the scattered forms, entry i in bits 4*i+3:4*i
   localparam logic [43:0] PermCj   = {4'd11, 4'd4, 4'd9, 4'd8, 4'd10, 4'd6,
                                       4'd7, 4'd3, 4'd2, 4'd1, 4'd5};
   localparam logic [43:0] PermCb   = {12'd0, 4'd8, 4'd4, 4'd3, 4'd7, 4'd6,
                                       4'd2, 4'd1, 4'd5};
   localparam logic [43:0] PermSp16 = {20'd0, 4'd9, 4'd4, 4'd6, 4'd8, 4'd7, 4'd5};
   localparam logic [43:0] PermSpn  = {12'd0, 4'd5, 4'd4, 4'd9, 4'd8, 4'd7,
                                       4'd6, 4'd2, 4'd3};

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   rvcc_pkg::req_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rvcc_pkg::rsp_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [rvcc_pkg::CsrAddrWidth-1:0] paddr;
   logic [rvcc_pkg::CsrDataWidth-1:0] pwdata;
   logic [rvcc_pkg::CsrDataWidth-1:0] prdata;
   logic pready;

   rvcc_pkg::rsp_type predicted_encodings[$];
   rvcc_pkg::rsp_type predicted;
   logic xlen_mode_shadow;
   int mismatch_count;
   int stall_cycles;
   int req_idle_pct;
   int rsp_idle_pct;

   rvc_instruction_compressor dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Encoder prediction
   // ------------------------------------------------------------------------
   function automatic bit is_creg(int unsigned r);
      return (r >> 3) == 1;
   endfunction

   function automatic int unsigned gather_bits(logic [31:0] u, logic [43:0] perm, int n);
      logic [31:0] r;
      int i;
      r = '0;
      for (i = 0; i < n; i++) r[i] = u[perm[4*i +: 4]];
      return r;
   endfunction

   function automatic int unsigned form_cr(int unsigned op, int unsigned rs, int unsigned rd);
      return op | ((rs & 'h1F) << 2) | ((rd & 'h1F) << 7);
   endfunction

   function automatic int unsigned form_ci(int unsigned op, int unsigned rd, int unsigned i);
      return op | ((rd & 'h1F) << 7) | ((i & 'h20) << 7) | ((i & 'h1F) << 2);
   endfunction

   function automatic int unsigned form_cl(int unsigned op, int unsigned hi, int unsigned lo,
                                           int unsigned i);
      return op | ((hi & 7) << 7) | ((lo & 7) << 2) | ((i & 7) << 4) | ((i & 'h38) << 7);
   endfunction

   function automatic int unsigned jump_form(int unsigned op, longint v, bit first);
      if (first || (v[0] == 1'b0 && v >= -2048 && v < 2048))
         return op | ((gather_bits(v[31:0], PermCj, 11) & 'h7FF) << 2);
      return 0;
   endfunction

   function automatic int unsigned branch_form(int unsigned op, int unsigned other,
                                               int unsigned src, longint v, bit first);
      int unsigned r;
      int unsigned i;
      r = other;
      // An absent or zero second operand means the source is compared with zero
      if (r == RegZero || r == RegAbsent) r = src;
      else if (src != RegZero) return 0;
      if (!is_creg(r)) return 0;
      if (first || (v[0] == 1'b0 && v >= -256 && v < 256)) begin
         i = gather_bits(v[31:0], PermCb, 8);
         return op | ((r & 7) << 7) | ((i & 'h1F) << 2) | ((i & 'hE0) << 5);
      end
      return 0;
   endfunction

   function automatic int unsigned mem_form(bit store, int unsigned op, longint len,
                                            longint maxoff, int unsigned base,
                                            int unsigned regn, longint off, bit nz_rd);
      int unsigned u;
      if (off < 0 || (off & (len - 1)) != 0) return 0;
      u = off[31:0];
      if (is_creg(base) && is_creg(regn)) begin
         if (off < maxoff) begin
            u = u | ((u >> 5) & ~32'd1);
            return form_cl(op, base, regn, u);
         end
      end else if (base == RegSp) begin
         // Stack-pointer forms reach twice as far as the register-class forms
         if (off < 2 * maxoff) begin
            u = u | (u >> 6);
            if (store)
               return (op | rvcc_pkg::OpcSpBit) | ((regn & 'h1F) << 2) | ((u & 'h3F) << 7);
            if (nz_rd && regn == RegZero) return 0;
            return form_ci(op | rvcc_pkg::OpcSpBit, regn, u);
         end
      end
      return 0;
   endfunction

   function automatic rvcc_pkg::rsp_type compress_request(rvcc_pkg::req_type q, logic mode);
      int unsigned sub;
      int unsigned rd;
      int unsigned rs;
      int unsigned r;
      int unsigned base;
      int unsigned op;
      int unsigned e;
      longint v;
      longint d;
      bit first;
      bit rv64;
      rvcc_pkg::rsp_type result;
      sub = q.sub_op;
      rd = q.dest_reg;
      rs = q.src_reg;
      r = q.other_reg;
      base = q.base_reg;
      v = longint'(signed'(q.imm));
      d = longint'(signed'(q.disp));
      first = q.first_pass;
      rv64 = (mode == XlenRv64);
      e = 0;
      case (q.op_class)
         rvcc_pkg::ClsAdd:
            if (rs != RegZero && rd != RegZero && r == rd)
               e = form_cr(rvcc_pkg::OpcAdd, rs, r);
         rvcc_pkg::ClsMv:
            if (rd != RegZero) begin
               if (q.src_is_register && rs != RegZero) e = form_cr(rvcc_pkg::OpcMv, rs, rd);
               else e = form_ci(rvcc_pkg::OpcLi, rd, 0);
            end
         rvcc_pkg::ClsJalr:
            if (r == RegLink && rd != RegZero && v == 0) e = form_cr(rvcc_pkg::OpcAdd, 0, rd);
         rvcc_pkg::ClsJr:
            if (rd != RegZero && v == 0) e = form_cr(rvcc_pkg::OpcMv, 0, rd);
         rvcc_pkg::ClsAlu:
            if (r == rd && is_creg(rs) && is_creg(rd))
               e = form_cr(rvcc_pkg::OpcAlu | (sub << 5), rs & 7, rd & 7);
         rvcc_pkg::ClsLi:
            if (rd != RegZero && v >= -32 && v < 32)
               e = form_ci(rvcc_pkg::OpcLi, rd, 32'(v & 'h3F));
         rvcc_pkg::ClsLui:
            if ((v & 'hFFF) == 0) begin
               v = v >>> 12;
               if (rd != RegZero && rd != RegSp && v != 0 && v >= -32 && v < 32)
                  e = form_ci(rvcc_pkg::OpcLui, rd, 32'(v & 'h3F));
            end
         rvcc_pkg::ClsSlli:
            if (!(v[5] && !rv64) && r == rd && r != RegZero && v >= 1 && v <= 63)
               e = form_ci(rvcc_pkg::OpcSlli, rd, v[31:0]);
         rvcc_pkg::ClsSrxi:
            if (!(v[5] && !rv64) && r == rd && is_creg(r) && v >= 1 && v <= 63) begin
               op = rvcc_pkg::OpcSrli |
                    ((sub == rvcc_pkg::SubAlt) ? rvcc_pkg::OpcSraBit : 16'h0);
               e = form_ci(op, r & 7, v[31:0]);
            end
         rvcc_pkg::ClsAddi:
            if (r == rd && r != RegZero && v != 0 && v >= -32 && v < 32)
               e = form_ci(rvcc_pkg::OpcAddi, rd, 32'(v & 'h3F));
            else if (r == rd && r == RegSp && v != 0 && (v & 'hF) == 0 && v >= -512 && v < 512)
               e = form_ci(OpcAddi16sp, RegSp, gather_bits(v[31:0], PermSp16, 6));
            else if (r == RegSp && is_creg(rd) && (v & 3) == 0 && v > 0 && v < 1024)
               e = ((rd & 7) << 2) | ((gather_bits(v[31:0], PermSpn, 8) & 'hFF) << 5);
            else if (r == rd && r == RegZero && v == 0)
               e = rvcc_pkg::OpcNop;
         rvcc_pkg::ClsJal:
            if (!rv64 && r == RegLink) e = jump_form(rvcc_pkg::OpcJal, d, first);
         rvcc_pkg::ClsJ:
            e = jump_form(rvcc_pkg::OpcJ, d, first);
         rvcc_pkg::ClsAndi:
            if (r == rd && is_creg(r) && v >= -32 && v < 32)
               e = form_ci(rvcc_pkg::OpcAndi, r & 7, 32'(v & 'h3F));
         rvcc_pkg::ClsBeqz:
            e = branch_form(rvcc_pkg::OpcBeqz, r, rs, d, first);
         rvcc_pkg::ClsBnez:
            e = branch_form(rvcc_pkg::OpcBnez, r, rs, d, first);
         rvcc_pkg::ClsLw:
            e = mem_form(1'b0, rvcc_pkg::OpcLw, 4, 128, base, rd, v, 1'b1);
         rvcc_pkg::ClsFlw:
            if (!rv64) e = mem_form(1'b0, rvcc_pkg::OpcFlw, 4, 128, base, rd, v, 1'b0);
         rvcc_pkg::ClsFld:
            e = mem_form(1'b0, rvcc_pkg::OpcFld, 8, 256, base, rd, v, 1'b0);
         rvcc_pkg::ClsSw:
            e = mem_form(1'b1, rvcc_pkg::OpcSw, 4, 128, base, rs, v, 1'b0);
         rvcc_pkg::ClsFsw:
            if (!rv64) e = mem_form(1'b1, rvcc_pkg::OpcFsw, 4, 128, base, rs, v, 1'b0);
         rvcc_pkg::ClsFsd:
            e = mem_form(1'b1, rvcc_pkg::OpcFsd, 8, 256, base, rs, v, 1'b0);
         rvcc_pkg::ClsAluW:
            if (rv64 && r == rd && is_creg(rs) && is_creg(rd))
               e = form_cr(rvcc_pkg::OpcAluW |
                           ((sub == rvcc_pkg::SubAlt) ? rvcc_pkg::OpcAddwBit : 16'h0),
                           rs & 7, rd & 7);
         rvcc_pkg::ClsAddiw:
            if (rv64) begin
               // A word move is sext.w, that is addiw of the source with zero
               if (q.is_move_word) begin
                  v = 0;
                  r = rs;
               end
               if (r == rd && r != RegZero && v >= -32 && v < 32)
                  e = form_ci(rvcc_pkg::OpcAddiw, rd, 32'(v & 'h3F));
            end
         rvcc_pkg::ClsLd:
            if (rv64) e = mem_form(1'b0, rvcc_pkg::OpcLd, 8, 256, base, rd, v, 1'b1);
         rvcc_pkg::ClsSd:
            if (rv64) e = mem_form(1'b1, rvcc_pkg::OpcSd, 8, 256, base, rs, v, 1'b0);
         default:
            e = 0;
      endcase
      result.encoding = e[15:0];
      result.compressible = (e[15:0] != 16'h0);
      return result;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic rvcc_pkg::req_type make_req(logic [4:0] cls, logic [1:0] sub,
                                                  logic [4:0] rd, logic [4:0] rs,
                                                  logic src_is_reg, logic [5:0] other,
                                                  logic [4:0] base, logic [31:0] imm,
                                                  logic [31:0] disp, logic first,
                                                  logic move_word);
      rvcc_pkg::req_type q;
      q.op_class = cls;
      q.sub_op = sub;
      q.dest_reg = rd;
      q.src_reg = rs;
      q.src_is_register = src_is_reg;
      q.other_reg = other;
      q.base_reg = base;
      q.imm = imm;
      q.disp = disp;
      q.first_pass = first;
      q.is_move_word = move_word;
      return q;
   endfunction

   function automatic logic [4:0] random_reg();
      case ($urandom_range(3))
         0: return 5'($urandom_range(8, 15));
         1: return 5'($urandom_range(0, 2));
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   // Mostly instructions that meet the register and range checks of some form,
   // with the rest free so that every field bit and every rejection is seen.
   function automatic rvcc_pkg::req_type random_request();
      rvcc_pkg::req_type q;
      int unsigned n;
      int value;
      n = $urandom_range(0, 99);
      if (n < 4) q.op_class = (n == 0) ? 5'd0 : 5'($urandom_range(26, 31));
      else q.op_class = 5'($urandom_range(1, 25));
      q.sub_op = 2'($urandom_range(0, 3));
      q.dest_reg = random_reg();
      q.src_reg = random_reg();
      q.src_is_register = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: q.other_reg = {1'b0, q.dest_reg};
         5: q.other_reg = 6'(RegAbsent);
         6: q.other_reg = 6'(RegZero);
         7: q.other_reg = 6'($urandom_range(RegLink, RegSp));
         default: q.other_reg = 6'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 6))
         0, 1, 2: q.base_reg = 5'(RegSp);
         3, 4: q.base_reg = 5'($urandom_range(8, 15));
         default: q.base_reg = 5'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 7))
         0: value = int'($urandom_range(0, 127)) - 64;
         1: value = int'($urandom_range(0, 70)) * 4;
         2: value = int'($urandom_range(0, 70)) * 8;
         3: value = (int'($urandom_range(0, 80)) - 40) * 4096;
         4: value = (int'($urandom_range(0, 70)) - 35) * 16;
         5: value = int'($urandom_range(0, 1100));
         6: value = int'($urandom());
         default: value = 0;
      endcase
      q.imm = 32'(value);
      case ($urandom_range(0, 4))
         0: value = (int'($urandom_range(0, 300)) - 150) * 2;
         1: value = (int'($urandom_range(0, 2200)) - 1100) * 2;
         2: value = int'($urandom_range(0, 600)) - 300;
         3: value = int'($urandom());
         default: value = 0;
      endcase
      q.disp = 32'(value);
      q.first_pass = ($urandom_range(0, 3) == 0);
      q.is_move_word = 1'($urandom_range(0, 1));
      return q;
   endfunction

   task automatic send_request(input rvcc_pkg::req_type q);
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (!req_ready);
      predicted_encodings.push_back(compress_request(q, xlen_mode_shadow));
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_encodings.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rvcc_pkg::CsrAddrWidth-1:0] addr,
                            input logic [rvcc_pkg::CsrDataWidth-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_check(input logic [rvcc_pkg::CsrAddrWidth-1:0] addr,
                            input logic [rvcc_pkg::CsrDataWidth-1:0] want);
      logic [rvcc_pkg::CsrDataWidth-1:0] got;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== want) begin
         $error("xlen_mode readback: expected %0h, actual %0h", want, got);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   // The mode is only changed once every outstanding request has been answered
   task automatic set_xlen_mode(input logic mode);
      wait_drained();
      csr_write(XlenModeAddr, {{(rvcc_pkg::CsrDataWidth-1){1'b0}}, mode});
      xlen_mode_shadow = mode;
      csr_check(XlenModeAddr, {{(rvcc_pkg::CsrDataWidth-1){1'b0}}, mode});
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_mode();
      csr_check(XlenModeAddr, {{(rvcc_pkg::CsrDataWidth-1){1'b0}}, rvcc_pkg::XlenRv32});
   endtask

   task automatic test_directed_rv32();
      set_xlen_mode(rvcc_pkg::XlenRv32);
      req_idle_pct = 33;
      rsp_idle_pct = 33;
      send_request(make_req(5'd0, 0, 5, 5, 1, 5, 8, 1, 2, 0, 0));
      send_request('1);
      send_request(make_req(rvcc_pkg::ClsAdd, 0, 5, 6, 0, 5, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsMv, 0, 10, 11, 1, RegAbsent, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsJalr, 0, 5, 0, 0, RegLink, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsJr, 0, 1, 0, 0, RegAbsent, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAlu, SubSub, 8, 15, 0, 8, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAlu, SubXor, 8, 15, 0, 8, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAlu, SubOr, 8, 15, 0, 8, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAlu, SubAnd, 8, 15, 0, 8, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsLi, 0, 31, 0, 0, RegAbsent, 0, -32, 0, 0, 0));
      // lui with a zero upper immediate is reserved
      send_request(make_req(rvcc_pkg::ClsLui, 0, 3, 0, 0, RegAbsent, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsLui, 0, 3, 0, 0, RegAbsent, 0, 32'hFFFE0000,
                            0, 0, 0));
      // A shift amount of 32 does not exist in RV32
      send_request(make_req(rvcc_pkg::ClsSlli, 0, 7, 0, 0, 7, 0, 32, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsSrxi, rvcc_pkg::SubAlt, 9, 0, 0, 9, 0, 31,
                            0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAddi, 0, RegSp, 0, 0, RegSp, 0, -512, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAddi, 0, 8, 0, 0, RegSp, 0, 1020, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAddi, 0, 0, 0, 0, RegZero, 0, 0, 0, 0, 0));
      // On the first pass an odd, far displacement is still encoded
      send_request(make_req(rvcc_pkg::ClsJal, 0, 0, 0, 0, RegLink, 0, 0, 32'h12345, 1, 0));
      send_request(make_req(rvcc_pkg::ClsJ, 0, 0, 0, 0, RegAbsent, 0, 0, -2048, 0, 0));
      send_request(make_req(rvcc_pkg::ClsBeqz, 0, 0, 10, 0, 6'd33, 0, 0, 10, 0, 0));
      send_request(make_req(rvcc_pkg::ClsBnez, 0, 0, 9, 0, RegAbsent, 0, 0, 254, 0, 0));
      // lwsp into x0 is reserved
      send_request(make_req(rvcc_pkg::ClsLw, 0, 0, 0, 0, RegAbsent, RegSp, 252, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsLw, 0, 9, 0, 0, RegAbsent, 8, 124, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsFld, 0, 4, 0, 0, RegAbsent, RegSp, 504, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsSw, 0, 0, 3, 0, RegAbsent, RegSp, 252, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsFsd, 0, 0, 12, 0, RegAbsent, 15, 248, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAndi, 0, 10, 0, 0, 10, 0, -1, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsLd, 0, 9, 0, 0, RegAbsent, RegSp, 8, 0, 0, 0));
   endtask

   task automatic test_directed_rv64();
      set_xlen_mode(XlenRv64);
      send_request(make_req(rvcc_pkg::ClsJal, 0, 0, 0, 0, RegLink, 0, 0, 64, 0, 0));
      send_request(make_req(rvcc_pkg::ClsFlw, 0, 9, 0, 0, RegAbsent, 8, 4, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsSlli, 0, 7, 0, 0, 7, 0, 63, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAluW, 0, 11, 12, 0, 11, 0, 0, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAluW, rvcc_pkg::SubAlt, 11, 12, 0, 11, 0, 0,
                            0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAddiw, 0, 20, 0, 0, 20, 0, 31, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsAddiw, 0, 20, 20, 0, RegAbsent, 0, 500, 0, 0, 1));
      send_request(make_req(rvcc_pkg::ClsLd, 0, 9, 0, 0, RegAbsent, RegSp, 504, 0, 0, 0));
      send_request(make_req(rvcc_pkg::ClsSd, 0, 0, 14, 0, RegAbsent, 13, 248, 0, 0, 0));
   endtask

   task automatic test_random(input int count, input logic mode, input int idle_pct);
      int i;
      set_xlen_mode(mode);
      req_idle_pct = idle_pct;
      rsp_idle_pct = idle_pct;
      for (i = 0; i < count; i++) begin
         // Halfway through, hold the sender back until the pipeline is empty
         if (i == count / 2) wait_drained();
         send_request(random_request());
      end
   endtask

   // ------------------------------------------------------------------------
   // Response checking and watchdog
   // ------------------------------------------------------------------------
   always @(negedge clock) rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_encodings.size() == 0) begin
            $error("response with no request outstanding: encoding %h",
                   rsp_payload.encoding);
            mismatch_count = mismatch_count + 1;
         end else begin
            predicted = predicted_encodings.pop_front();
            if (rsp_payload.encoding !== predicted.encoding) begin
               $error("encoding: expected %h, actual %h",
                      predicted.encoding, rsp_payload.encoding);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_payload.compressible !== predicted.compressible) begin
               $error("compressible: expected %b, actual %b",
                      predicted.compressible, rsp_payload.compressible);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      xlen_mode_shadow = rvcc_pkg::XlenRv32;
      mismatch_count = 0;
      req_idle_pct = 33;
      rsp_idle_pct = 33;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_mode();
      test_directed_rv32();
      test_directed_rv64();
      test_random(125, XlenRv64, 33);
      test_random(125, rvcc_pkg::XlenRv32, 0);
      test_random(125, XlenRv64, 0);
      test_random(125, rvcc_pkg::XlenRv32, 33);

      wait_drained();
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0 && predicted_encodings.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
